/* src/csem_pkg.sv */
// Package for the counting semaphore table: table size, field widths,
// command and status codes. Used by the top level; no dependencies.
`default_nettype none

package csem_pkg;

  localparam int NUM_SEMS = 64;
  localparam int ID_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

  localparam int FUNC_W   = 3;
  localparam int SID_W    = 8;
  localparam int CNT_W    = 16;
  localparam int STAT_W   = 2;
  localparam int NEWID_W  = 6;
  localparam int WAKE_W   = 16;

  localparam logic [SID_W:0] SEM_LIMIT = (SID_W + 1)'(NUM_SEMS);

  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WAIT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POST  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;

endpackage

`default_nettype wire

/* src/counting_semaphore_table_unit.sv */
// Top level of the counting semaphore table: command decode, in-use bits,
// read-modify-write of the count memory. Depends on csem_pkg and csem_ram.
//
//   Channel  Ports                                      Direction
//   in       in_valid, in_ready, in_func, in_sem_id,   command in
//            in_initial_value
//   out      out_valid, out_ready, out_status,         result out
//            out_new_id, out_count_value, out_must_block, out_wake_count
//
// Each command passes through S_IDLE, which issues the count memory read, and
// S_EXEC, which modifies, writes back and loads the result register; a new
// command is taken only in S_IDLE. S_EXEC waits while an earlier result is
// still untaken. Reset clears the in-use bits at once; no clearing pass.
`default_nettype none

module counting_semaphore_table_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [csem_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [csem_pkg::SID_W-1:0]      in_sem_id,
  input  wire logic signed [csem_pkg::CNT_W-1:0] in_initial_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [csem_pkg::STAT_W-1:0]          out_status,
  output logic [csem_pkg::NEWID_W-1:0]         out_new_id,
  output logic signed [csem_pkg::CNT_W-1:0]    out_count_value,
  output logic                                 out_must_block,
  output logic [csem_pkg::WAKE_W-1:0]          out_wake_count
);
  import csem_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [NUM_SEMS-1:0] in_use_r, in_use_nxt;

  logic [FUNC_W-1:0]       func_r;
  logic [SID_W-1:0]        id_r;
  logic signed [CNT_W-1:0] init_r;

  logic [STAT_W-1:0]       status_r;
  logic [NEWID_W-1:0]      new_id_r;
  logic signed [CNT_W-1:0] count_r;
  logic                    block_r;
  logic [WAKE_W-1:0]       wake_r;

  logic                    in_fire;
  logic                    exec_go;
  logic [ID_W-1:0]         idx;
  logic [ID_W-1:0]         rd_addr;
  logic [ID_W-1:0]         wr_addr;
  logic                    wr_en;
  logic signed [CNT_W-1:0] wr_data;
  logic signed [CNT_W-1:0] rd_data;
  logic                    id_ok;
  logic                    free_found;
  logic [ID_W-1:0]         free_slot;

  logic [STAT_W-1:0]       res_status;
  logic [NEWID_W-1:0]      res_new_id;
  logic signed [CNT_W-1:0] res_count;
  logic                    res_block;
  logic [WAKE_W-1:0]       res_wake;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign idx      = id_r[ID_W-1:0];
  assign rd_addr  = (state_r == S_IDLE) ? in_sem_id[ID_W-1:0] : idx;
  assign id_ok    = ({1'b0, id_r} < SEM_LIMIT) && in_use_r[idx];

  csem_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_SEMS)
  ) u_count_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_slot  = ID_W'(i);
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_new_id = '0;
    res_count  = '0;
    res_block  = 1'b0;
    res_wake   = '0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = '0;
    in_use_nxt = in_use_r;
    case (func_r)
      FN_ALLOC: begin
        if (free_found) begin
          res_new_id            = NEWID_W'(free_slot);
          res_count             = init_r;
          wr_en                 = exec_go;
          wr_addr               = free_slot;
          wr_data               = init_r;
          in_use_nxt[free_slot] = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      FN_FREE: begin
        if (id_ok) begin
          if (rd_data < 0) begin
            res_wake = WAKE_W'(~rd_data + 16'sd1);
          end
          wr_en           = exec_go;
          in_use_nxt[idx] = 1'b0;
        end else begin
          res_status = ST_BAD_ID;
        end
      end
      FN_WAIT: begin
        if (id_ok) begin
          res_count = (rd_data == CNT_MIN) ? rd_data : rd_data - 16'sd1;
          res_block = (res_count < 0);
          wr_en     = exec_go;
          wr_data   = res_count;
        end else begin
          res_status = ST_BAD_ID;
        end
      end
      FN_POST: begin
        if (id_ok) begin
          res_count = (rd_data == CNT_MAX) ? rd_data : rd_data + 16'sd1;
          res_wake  = (res_count <= 0) ? WAKE_W'(1) : '0;
          wr_en     = exec_go;
          wr_data   = res_count;
        end else begin
          res_status = ST_BAD_ID;
        end
      end
      FN_READ: begin
        if (id_ok) begin
          res_count = rd_data;
        end else begin
          res_status = ST_BAD_ID;
        end
      end
      default: begin
        res_status = ST_BAD_ID;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      in_use_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        in_use_r <= in_use_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      id_r   <= in_sem_id;
      init_r <= in_initial_value;
    end
    if (exec_go) begin
      status_r <= res_status;
      new_id_r <= res_new_id;
      count_r  <= res_count;
      block_r  <= res_block;
      wake_r   <= res_wake;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_new_id      = new_id_r;
  assign out_count_value = count_r;
  assign out_must_block  = block_r;
  assign out_wake_count  = wake_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("Accepted command did not move to the execute cycle.");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exec_go))
    else $error("Result appeared without an execute cycle.");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && (res_status == ST_FULL)) |-> (&in_use_r))
    else $error("Table full reported while a slot is free.");

  a_alloc_claims_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && (func_r == FN_ALLOC) && (res_status == ST_OK))
      |=> ($countones(in_use_r) == $past($countones(in_use_r)) + 1))
    else $error("Allocate did not claim exactly one slot.");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (res_status != ST_OK) |-> !wr_en)
    else $error("Count memory written by a failed command.");
`endif

endmodule

`default_nettype wire

/* src/csem_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the semaphore counts; no dependencies.
`default_nettype none

module csem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
